// ===== src/bcdrtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdrtc_pkg
// Shared types, constants and calendar helpers for the BCD real-time clock.
// ----------------------------------------------------------------------------
package bcdrtc_pkg;

  typedef logic [12:0][3:0] bank_t;

  localparam logic [1:0] CMD_SELECT  = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_ADVANCE = 2'd3;

  localparam logic [3:0] REGS_PER_BANK = 4'd13;
  localparam logic [3:0] ADDR_MODE     = 4'hD;
  localparam logic [3:0] ADDR_RESET    = 4'hF;
  localparam logic [3:0] REG_FMT       = 4'd10;
  localparam logic [3:0] REG_LEAP      = 4'd11;
  localparam int         MODE_TIMER    = 3;

  localparam logic [31:0] DEFAULT_CPS    = 32'd3579545;
  localparam logic [31:0] SEC_PER_MIN    = 32'd60;
  localparam logic [31:0] HOUR_PER_DAY   = 32'd24;
  localparam logic [31:0] DAYS_PER_WEEK  = 32'd7;
  localparam logic [31:0] DAYS_PER_QUAD  = 32'd1461;
  localparam logic [31:0] QUADS_PER_CENT = 32'd25;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_NORM, ST_DIV_PERIOD, ST_DIV_SEC, ST_DIV_MIN,
    ST_DIV_HOUR, ST_DIV_WDAY, ST_DIV_DAYS, ST_DIV_YEAR, ST_DAYS
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_EXEC, OP_NORM, OP_APPLY_PERIOD, OP_APPLY_SEC,
    OP_APPLY_MIN, OP_APPLY_HOUR, OP_APPLY_WDAY, OP_APPLY_DAYS,
    OP_APPLY_YEAR, OP_NEXT_DAY
  } op_t;

  typedef struct packed {
    op_t  op;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       need_norm;
    logic       adv_div;
    logic       div_done;
    logic       days_zero;
    logic       days_last;
  } sts_t;

  function automatic logic [7:0] tval(input logic [3:0] lo, input logic [3:0] hi);
    return 8'(lo) + 8'(hi) * 8'd10;
  endfunction

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] tv;
    t = '0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(i * 10)) t = 4'(i);
    end
    tv = 7'(t) * 7'd10;
    return {t, 4'(v - tv)};
  endfunction

  function automatic logic [4:0] month_days(input logic [7:0] m, input logic [1:0] leap);
    if (m == 8'd2) return (leap == 2'd0) ? 5'd29 : 5'd28;
    if (m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11) return 5'd30;
    return 5'd31;
  endfunction

  function automatic logic [3:0] clampd(input logic [3:0] v, input logic [3:0] m);
    return (v > m) ? m : v;
  endfunction

  function automatic bank_t normalize(input bank_t b, input logic [1:0] leap);
    bank_t      r;
    logic [4:0] md;
    logic [7:0] bc;
    r = b;
    r[0] = clampd(r[0], 4'd9);
    r[1] = clampd(r[1], 4'd5);
    r[2] = clampd(r[2], 4'd9);
    r[3] = clampd(r[3], 4'd5);
    r[4] = clampd(r[4], 4'd9);
    r[5] = clampd(r[5], 4'd2);
    if (tval(r[4], r[5]) > 8'd23) begin
      r[4] = 4'd3;
      r[5] = 4'd2;
    end
    r[6] = clampd(r[6], 4'd6);
    if (tval(r[7], r[8]) == 8'd0) begin
      r[7] = 4'd1;
      r[8] = 4'd0;
    end
    md = month_days(tval(r[9], r[10]), leap);
    if (tval(r[7], r[8]) > 8'(md)) begin
      bc   = to_bcd(7'(md));
      r[8] = bc[7:4];
      r[7] = bc[3:0];
    end
    if (tval(r[9], r[10]) == 8'd0) begin
      r[9]  = 4'd1;
      r[10] = 4'd0;
    end
    if (tval(r[9], r[10]) > 8'd12) begin
      r[9]  = 4'd2;
      r[10] = 4'd1;
    end
    r[11] = clampd(r[11], 4'd9);
    r[12] = clampd(r[12], 4'd9);
    return r;
  endfunction

endpackage

// ===== src/bcdrtc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdrtc_ctrl
// Sequencer: command execution, write clamping and the carry/division chain.
// ----------------------------------------------------------------------------
module bcdrtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bcdrtc_pkg::sts_t  sts,
  output bcdrtc_pkg::ctl_t  ctl,
  output logic              busy
);

  bcdrtc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcdrtc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcdrtc_pkg::ST_IDLE: begin
        if (start) state_nxt = bcdrtc_pkg::ST_EXEC;
      end
      bcdrtc_pkg::ST_EXEC: begin
        if (sts.cmd == bcdrtc_pkg::CMD_WRITE && sts.need_norm)
          state_nxt = bcdrtc_pkg::ST_NORM;
        else if (sts.cmd == bcdrtc_pkg::CMD_ADVANCE && sts.adv_div)
          state_nxt = bcdrtc_pkg::ST_DIV_PERIOD;
        else
          state_nxt = bcdrtc_pkg::ST_IDLE;
      end
      bcdrtc_pkg::ST_NORM: state_nxt = bcdrtc_pkg::ST_IDLE;
      bcdrtc_pkg::ST_DIV_PERIOD: if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_SEC;
      bcdrtc_pkg::ST_DIV_SEC:    if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_MIN;
      bcdrtc_pkg::ST_DIV_MIN:    if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_HOUR;
      bcdrtc_pkg::ST_DIV_HOUR:   if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_WDAY;
      bcdrtc_pkg::ST_DIV_WDAY:   if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_DAYS;
      bcdrtc_pkg::ST_DIV_DAYS:   if (sts.div_done) state_nxt = bcdrtc_pkg::ST_DIV_YEAR;
      bcdrtc_pkg::ST_DIV_YEAR: begin
        if (sts.div_done)
          state_nxt = sts.days_zero ? bcdrtc_pkg::ST_IDLE : bcdrtc_pkg::ST_DAYS;
      end
      bcdrtc_pkg::ST_DAYS: if (sts.days_last) state_nxt = bcdrtc_pkg::ST_IDLE;
      default: state_nxt = bcdrtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op     = bcdrtc_pkg::OP_NONE;
    ctl.finish = 1'b0;
    unique case (state_r)
      bcdrtc_pkg::ST_IDLE: if (start) ctl.op = bcdrtc_pkg::OP_LATCH;
      bcdrtc_pkg::ST_EXEC: begin
        ctl.op = bcdrtc_pkg::OP_EXEC;
        ctl.finish = !((sts.cmd == bcdrtc_pkg::CMD_WRITE && sts.need_norm) ||
                       (sts.cmd == bcdrtc_pkg::CMD_ADVANCE && sts.adv_div));
      end
      bcdrtc_pkg::ST_NORM: begin
        ctl.op     = bcdrtc_pkg::OP_NORM;
        ctl.finish = 1'b1;
      end
      bcdrtc_pkg::ST_DIV_PERIOD: if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_PERIOD;
      bcdrtc_pkg::ST_DIV_SEC:    if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_SEC;
      bcdrtc_pkg::ST_DIV_MIN:    if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_MIN;
      bcdrtc_pkg::ST_DIV_HOUR:   if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_HOUR;
      bcdrtc_pkg::ST_DIV_WDAY:   if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_WDAY;
      bcdrtc_pkg::ST_DIV_DAYS:   if (sts.div_done) ctl.op = bcdrtc_pkg::OP_APPLY_DAYS;
      bcdrtc_pkg::ST_DIV_YEAR: begin
        if (sts.div_done) begin
          ctl.op     = bcdrtc_pkg::OP_APPLY_YEAR;
          ctl.finish = sts.days_zero;
        end
      end
      bcdrtc_pkg::ST_DAYS: begin
        ctl.op     = bcdrtc_pkg::OP_NEXT_DAY;
        ctl.finish = sts.days_last;
      end
      default: ctl.op = bcdrtc_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_r != bcdrtc_pkg::ST_IDLE);

endmodule

// ===== src/bcdrtc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdrtc_dp
// Register banks, sub-second counter, bit-serial period divider, radix-16
// constant divider and calendar logic.
// ----------------------------------------------------------------------------
module bcdrtc_dp #(
  parameter int CYCLE_COUNT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bcdrtc_pkg::ctl_t             ctl,
  output bcdrtc_pkg::sts_t             sts,
  input  logic [1:0]                   in_command,
  input  logic [3:0]                   in_value,
  input  logic [CYCLE_COUNT_WIDTH-1:0] in_cycle_count,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  output logic                         out_valid,
  output logic [3:0]                   out_read_data
);

  localparam int DW   = CYCLE_COUNT_WIDTH + 1;
  localparam int NDIG = (DW + 3) / 4;
  localparam int DQW  = 4 * NDIG;
  localparam int CNTW = $clog2(DW + 1);
  localparam int XW   = CYCLE_COUNT_WIDTH + 34;

  logic [1:0]                   cmd_r;
  logic [3:0]                   val_r;
  logic [CYCLE_COUNT_WIDTH-1:0] cnt_r;

  bcdrtc_pkg::bank_t bank0_r, bank1_r, bank2_r, bank3_r;
  bcdrtc_pkg::bank_t bank0_nxt, bank1_nxt, bank2_nxt, bank3_nxt;
  logic [3:0]  sel_r, sel_nxt, mode_r, mode_nxt;
  logic [31:0] sub_r, sub_nxt, cps_r, cps_nxt;
  logic [DQW-1:0] carry_r, carry_nxt;
  logic [10:0] days_r, days_nxt;
  logic [DQW-1:0] dq_r, dq_nxt;
  logic [31:0] drem_r, drem_nxt, ddiv_r, ddiv_nxt;
  logic [CNTW-1:0] dcnt_r, dcnt_nxt;
  logic        rad_r, rad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_read_data_r, out_read_data_nxt;

  logic [1:0]  bank;
  logic        in_bank;
  logic [3:0]  rd_nib;
  logic [31:0] period;
  logic [32:0] need;
  logic [XW-1:0] cx, nx;
  logic        adv_div;
  logic [1:0]  leap;
  logic [32:0] rsh;
  logic [14:0] dv, dr, dm;
  logic [3:0]  qd;
  logic [6:0]  sum;
  logic        c;
  logic [7:0]  bc, y, d, m;
  logic [4:0]  md;
  logic [3:0]  wd;
  logic [DQW-1:0] nc;

  assign bank    = mode_r[1:0];
  assign in_bank = sel_r < bcdrtc_pkg::REGS_PER_BANK;
  assign leap    = bank1_r[bcdrtc_pkg::REG_LEAP][1:0];
  assign period  = (cps_r == 32'd0) ? 32'd1 : cps_r;
  assign need    = (sub_r >= period) ? 33'd1 : ({1'b0, period} - {1'b0, sub_r});
  assign cx      = XW'(cnt_r);
  assign nx      = XW'(need);
  assign adv_div = mode_r[bcdrtc_pkg::MODE_TIMER] && (cx >= nx);

  always_comb begin
    rd_nib = 4'd0;
    if (sel_r == bcdrtc_pkg::ADDR_MODE) begin
      rd_nib = mode_r;
    end else if (in_bank) begin
      unique case (bank)
        2'd0: rd_nib = bank0_r[sel_r];
        2'd1: rd_nib = bank1_r[sel_r];
        2'd2: rd_nib = bank2_r[sel_r];
        2'd3: rd_nib = bank3_r[sel_r];
        default: rd_nib = 4'd0;
      endcase
    end
  end

  always_comb begin
    sts.cmd       = cmd_r;
    sts.need_norm = in_bank && (bank == 2'd0 || (bank == 2'd1 &&
                    (sel_r == bcdrtc_pkg::REG_FMT || sel_r == bcdrtc_pkg::REG_LEAP)));
    sts.adv_div   = adv_div;
    sts.div_done  = (dcnt_r == '0);
    sts.days_zero = (days_r == 11'd0);
    sts.days_last = (days_r == 11'd1);
  end

  always_comb begin
    bank0_nxt = bank0_r;
    bank1_nxt = bank1_r;
    bank2_nxt = bank2_r;
    bank3_nxt = bank3_r;
    sel_nxt   = sel_r;
    mode_nxt  = mode_r;
    sub_nxt   = sub_r;
    cps_nxt   = cfg_we ? cfg_wdata : cps_r;
    carry_nxt = carry_r;
    days_nxt  = days_r;
    dq_nxt    = dq_r;
    drem_nxt  = drem_r;
    ddiv_nxt  = ddiv_r;
    dcnt_nxt  = dcnt_r;
    rad_nxt   = rad_r;
    sum = '0;
    c   = 1'b0;
    bc  = '0;
    y   = '0;
    d   = '0;
    m   = '0;
    md  = '0;
    wd  = '0;
    nc  = '0;
    rsh = {drem_r, dq_r[DW-1]};
    dv  = {drem_r[10:0], dq_r[DQW-1 -: 4]};
    dr  = dv;
    dm  = '0;
    qd  = '0;
    if (dcnt_r != '0) begin
      if (rad_r) begin
        // one quotient digit per cycle against the multiples of the constant
        for (int j = 1; j < 16; j++) begin
          dm = ddiv_r[14:0] * 15'(j);
          if (dv >= dm) begin
            qd = 4'(j);
            dr = dv - dm;
          end
        end
        drem_nxt = 32'(dr);
        dq_nxt   = {dq_r[DQW-5:0], qd};
      end else if (rsh >= {1'b0, ddiv_r}) begin
        drem_nxt = 32'(rsh - {1'b0, ddiv_r});
        dq_nxt   = DQW'({dq_r[DW-2:0], 1'b1});
      end else begin
        drem_nxt = rsh[31:0];
        dq_nxt   = DQW'({dq_r[DW-2:0], 1'b0});
      end
      dcnt_nxt = dcnt_r - 1'b1;
    end
    unique case (ctl.op)
      bcdrtc_pkg::OP_EXEC: begin
        unique case (cmd_r)
          bcdrtc_pkg::CMD_SELECT: sel_nxt = val_r;
          bcdrtc_pkg::CMD_WRITE: begin
            if (sel_r == bcdrtc_pkg::ADDR_MODE) begin
              mode_nxt = val_r;
            end else if (sel_r == bcdrtc_pkg::ADDR_RESET) begin
              if (val_r[0]) begin
                for (int i = 0; i < 9; i++) bank1_nxt[i] = 4'd0;
              end
              if (val_r[1]) sub_nxt = 32'd0;
            end else if (in_bank) begin
              unique case (bank)
                2'd0: bank0_nxt[sel_r] = val_r;
                2'd1: bank1_nxt[sel_r] = val_r;
                2'd2: bank2_nxt[sel_r] = val_r;
                2'd3: bank3_nxt[sel_r] = val_r;
                default: bank0_nxt = bank0_r;
              endcase
            end
          end
          bcdrtc_pkg::CMD_READ: sel_nxt = sel_r;
          bcdrtc_pkg::CMD_ADVANCE: begin
            if (mode_r[bcdrtc_pkg::MODE_TIMER]) begin
              if (!adv_div) begin
                sub_nxt = sub_r + cx[31:0];
              end else begin
                dq_nxt   = DQW'(cx - nx);
                ddiv_nxt = period;
                drem_nxt = '0;
                dcnt_nxt = CNTW'(DW);
                rad_nxt  = 1'b0;
              end
            end
          end
          default: sel_nxt = sel_r;
        endcase
      end
      bcdrtc_pkg::OP_NORM: begin
        bank0_nxt = bcdrtc_pkg::normalize(bank0_r, leap);
        bank1_nxt[bcdrtc_pkg::REG_FMT]  = bank1_r[bcdrtc_pkg::REG_FMT] & 4'd3;
        bank1_nxt[bcdrtc_pkg::REG_LEAP] = bank1_r[bcdrtc_pkg::REG_LEAP] & 4'd3;
      end
      bcdrtc_pkg::OP_APPLY_PERIOD: begin
        sub_nxt  = drem_r;
        dq_nxt   = dq_r + 1'b1;
        ddiv_nxt = bcdrtc_pkg::SEC_PER_MIN;
        drem_nxt = '0;
        dcnt_nxt = CNTW'(NDIG);
        rad_nxt  = 1'b1;
      end
      bcdrtc_pkg::OP_APPLY_SEC, bcdrtc_pkg::OP_APPLY_MIN: begin
        if (ctl.op == bcdrtc_pkg::OP_APPLY_SEC)
          sum = 7'(bcdrtc_pkg::tval(bank0_r[0], bank0_r[1])) + 7'(drem_r[5:0]);
        else
          sum = 7'(bcdrtc_pkg::tval(bank0_r[2], bank0_r[3])) + 7'(drem_r[5:0]);
        if (sum >= 7'd60) begin
          sum = sum - 7'd60;
          c   = 1'b1;
        end
        bc = bcdrtc_pkg::to_bcd(sum);
        if (ctl.op == bcdrtc_pkg::OP_APPLY_SEC) begin
          bank0_nxt[0] = bc[3:0];
          bank0_nxt[1] = bc[7:4];
          ddiv_nxt     = bcdrtc_pkg::SEC_PER_MIN;
        end else begin
          bank0_nxt[2] = bc[3:0];
          bank0_nxt[3] = bc[7:4];
          ddiv_nxt     = bcdrtc_pkg::HOUR_PER_DAY;
        end
        nc       = dq_r + DQW'(c);
        dq_nxt   = nc;
        drem_nxt = '0;
        dcnt_nxt = CNTW'(NDIG);
      end
      bcdrtc_pkg::OP_APPLY_HOUR: begin
        sum = 7'(bcdrtc_pkg::tval(bank0_r[4], bank0_r[5])) + 7'(drem_r[4:0]);
        if (sum >= 7'd24) begin
          sum = sum - 7'd24;
          c   = 1'b1;
        end
        bc = bcdrtc_pkg::to_bcd(sum);
        bank0_nxt[4] = bc[3:0];
        bank0_nxt[5] = bc[7:4];
        nc        = dq_r + DQW'(c);
        carry_nxt = nc;
        dq_nxt    = nc;
        ddiv_nxt  = bcdrtc_pkg::DAYS_PER_WEEK;
        drem_nxt  = '0;
        dcnt_nxt  = CNTW'(NDIG);
      end
      bcdrtc_pkg::OP_APPLY_WDAY: begin
        wd = bank0_r[6] + drem_r[3:0];
        if (wd >= 4'd7) wd = wd - 4'd7;
        bank0_nxt[6] = wd;
        dq_nxt   = carry_r;
        ddiv_nxt = bcdrtc_pkg::DAYS_PER_QUAD;
        drem_nxt = '0;
        dcnt_nxt = CNTW'(NDIG);
      end
      bcdrtc_pkg::OP_APPLY_DAYS: begin
        days_nxt = drem_r[10:0];
        dq_nxt   = dq_r;
        ddiv_nxt = bcdrtc_pkg::QUADS_PER_CENT;
        drem_nxt = '0;
        dcnt_nxt = CNTW'(NDIG);
      end
      bcdrtc_pkg::OP_APPLY_YEAR: begin
        y = bcdrtc_pkg::tval(bank0_r[11], bank0_r[12]) + {1'b0, drem_r[4:0], 2'b00};
        if (y >= 8'd100) y = y - 8'd100;
        bc = bcdrtc_pkg::to_bcd(y[6:0]);
        bank0_nxt[11] = bc[3:0];
        bank0_nxt[12] = bc[7:4];
      end
      bcdrtc_pkg::OP_NEXT_DAY: begin
        days_nxt = days_r - 1'b1;
        d  = bcdrtc_pkg::tval(bank0_r[7], bank0_r[8]) + 8'd1;
        md = bcdrtc_pkg::month_days(bcdrtc_pkg::tval(bank0_r[9], bank0_r[10]), leap);
        if (d <= 8'(md)) begin
          bc = bcdrtc_pkg::to_bcd(d[6:0]);
          bank0_nxt[7] = bc[3:0];
          bank0_nxt[8] = bc[7:4];
        end else begin
          bank0_nxt[7] = 4'd1;
          bank0_nxt[8] = 4'd0;
          m = bcdrtc_pkg::tval(bank0_r[9], bank0_r[10]) + 8'd1;
          if (m <= 8'd12) begin
            bc = bcdrtc_pkg::to_bcd(m[6:0]);
            bank0_nxt[9]  = bc[3:0];
            bank0_nxt[10] = bc[7:4];
          end else begin
            bank0_nxt[9]  = 4'd1;
            bank0_nxt[10] = 4'd0;
            y = bcdrtc_pkg::tval(bank0_r[11], bank0_r[12]) + 8'd1;
            if (y >= 8'd100) y = y - 8'd100;
            bc = bcdrtc_pkg::to_bcd(y[6:0]);
            bank0_nxt[11] = bc[3:0];
            bank0_nxt[12] = bc[7:4];
            bank1_nxt[bcdrtc_pkg::REG_LEAP] = {2'b00, leap + 2'd1};
          end
        end
      end
      default: sel_nxt = sel_r;
    endcase
    out_valid_nxt     = ctl.finish;
    out_read_data_nxt = (ctl.finish && cmd_r == bcdrtc_pkg::CMD_READ) ? rd_nib : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank0_r         <= '0;
      bank0_r[7]      <= 4'd1;
      bank0_r[9]      <= 4'd1;
      bank1_r         <= '0;
      bank1_r[bcdrtc_pkg::REG_FMT] <= 4'd1;
      bank2_r         <= '0;
      bank2_r[0]      <= 4'hA;
      bank2_r[12]     <= 4'h2;
      bank3_r         <= '0;
      sel_r           <= '0;
      mode_r          <= 4'd8;
      sub_r           <= '0;
      cps_r           <= bcdrtc_pkg::DEFAULT_CPS;
      days_r          <= '0;
      dcnt_r          <= '0;
      out_valid_r     <= 1'b0;
      out_read_data_r <= '0;
    end else begin
      bank0_r         <= bank0_nxt;
      bank1_r         <= bank1_nxt;
      bank2_r         <= bank2_nxt;
      bank3_r         <= bank3_nxt;
      sel_r           <= sel_nxt;
      mode_r          <= mode_nxt;
      sub_r           <= sub_nxt;
      cps_r           <= cps_nxt;
      days_r          <= days_nxt;
      dcnt_r          <= dcnt_nxt;
      out_valid_r     <= out_valid_nxt;
      out_read_data_r <= out_read_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    dq_r    <= dq_nxt;
    drem_r  <= drem_nxt;
    ddiv_r  <= ddiv_nxt;
    rad_r   <= rad_nxt;
    if (ctl.op == bcdrtc_pkg::OP_LATCH) begin
      cmd_r <= in_command;
      val_r <= in_value;
      cnt_r <= in_cycle_count;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

endmodule

// ===== src/bcd_real_time_clock_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_real_time_clock_registers
// BCD real-time clock with nibble register port and calendar advance.
// ----------------------------------------------------------------------------
// Select, read and write-to-other registers: result registered after the EXEC state.
// Clamped writes (time bank, 12/24 flag, leap counter) pass through the NORM state.
// Advance with whole seconds: a bit-serial period divide over W+1 bits (W =
// CYCLE_COUNT_WIDTH), then six radix-16 constant divides, then the calendar steps
// one leftover day per cycle (up to 1460). One transaction at a time.
// Synchronous active-low reset restores the power-on register contents.
module bcd_real_time_clock_registers #(
  parameter int CYCLE_COUNT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [3:0]                   in_value,
  input  logic [CYCLE_COUNT_WIDTH-1:0] in_cycle_count,
  input  logic                         cfg_we,
  input  logic [31:0]                  cfg_wdata,
  output logic                         out_valid,
  output logic [3:0]                   out_read_data
);

  bcdrtc_pkg::ctl_t ctl;
  bcdrtc_pkg::sts_t sts;

  bcdrtc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  bcdrtc_dp #(
    .CYCLE_COUNT_WIDTH (CYCLE_COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_cycle_count (in_cycle_count),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data)
  );

endmodule

// ===== src/bcdrtc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdrtc_chk
// Port-level checks on the transaction sequencing of the clock block.
// ----------------------------------------------------------------------------
module bcdrtc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_read_data
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy still high with result");

  a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_read_data != 4'd0 |-> out_valid) else $error("data outside strobe");

endmodule

bind bcd_real_time_clock_registers bcdrtc_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_data (out_read_data)
);
